[src/kem_pkg.sv]
// kem_pkg: types, constants and helper functions shared by the effective mass pipeline
// depends on nothing
package kem_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int FRACTION_BITS = 24;
   localparam int LIM_BITS      = 61;
   localparam int SW            = LIM_BITS + 2;
   localparam int MW            = LIM_BITS + 1;
   localparam int XW            = ((DATA_WIDTH > SW) ? DATA_WIDTH : SW) + 2;
   localparam int DVW           = LIM_BITS + 2;
   localparam int DIV_EXP       = 2 * FRACTION_BITS + 1;
   localparam int QW            = DIV_EXP + 1;
   localparam int HW            = (MW + 1) / 2;
   localparam int PW            = 2 * HW;
   localparam int D3_CHUNK      = 8;
   localparam int D3_STAGES     = (MW + D3_CHUNK - 1) / D3_CHUNK;
   localparam int D3W           = D3_STAGES * D3_CHUNK;
   localparam int CW            = ((QW > DATA_WIDTH) ? QW : DATA_WIDTH) + 1;
   localparam int FRONT_STAGES  = 6;
   localparam int MID_STAGES    = 6 + D3_STAGES;
   localparam int PIPE_LATENCY  = FRONT_STAGES + QW + MID_STAGES + QW + 1;
   localparam int CSR_WIDTH     = 32;
   localparam int PADDR_WIDTH   = 3;

   localparam logic REG_BAND_MODEL = 1'b0;
   localparam logic MODEL_ZINCBLENDE = 1'b0;

   localparam logic signed [XW-1:0] XLIM_POS = XW'(1) << LIM_BITS;
   localparam logic signed [XW-1:0] XLIM_NEG = -XLIM_POS;
   localparam logic signed [SW-1:0] LIM_POS  = SW'(1) << LIM_BITS;
   localparam logic [MW-1:0]        LIM_MAG  = MW'(1) << LIM_BITS;
   localparam logic signed [SW-1:0] ONE_Q    = SW'(1) << FRACTION_BITS;
   localparam logic [CW-1:0] OUT_POS_MAX = (CW'(1) << (DATA_WIDTH - 1)) - CW'(1);
   localparam logic [CW-1:0] OUT_NEG_MAG = CW'(1) << (DATA_WIDTH - 1);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] trial_energy;
      logic signed [DATA_WIDTH-1:0] band_potential;
      logic signed [DATA_WIDTH-1:0] gap_energy;
      logic signed [DATA_WIDTH-1:0] kane_param;
      logic signed [DATA_WIDTH-1:0] matrix_energy;
      logic signed [DATA_WIDTH-1:0] split_off_energy;
      logic                         last_position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] mass_ratio;
      logic                         saturated;
      logic                         last_out;
   } rsp_type;

   typedef struct packed {
      logic                 zero1;
      logic                 zero2;
      logic                 neg2;
      logic signed [SW-1:0] kane2;
      logic signed [SW-1:0] matrix;
      logic                 last;
      logic                 sat;
   } side_type;

   typedef struct packed {
      logic [DVW-1:0] div1;
      logic [DVW-1:0] div2;
      side_type       side;
   } front_type;

   typedef struct packed {
      logic zero3;
      logic neg3;
      logic last;
      logic sat;
   } side3_type;

   typedef struct packed {
      logic [DVW-1:0] div3;
      side3_type      side;
   } mid_type;

   typedef struct packed {
      logic signed [SW-1:0] val;
      logic                 sat;
   } clamp_type;

   function automatic clamp_type clamp_lim(input logic signed [XW-1:0] x);
      clamp_type c;
      if (x > XLIM_POS) begin
         c.val = LIM_POS;
         c.sat = 1'b1;
      end else if (x < XLIM_NEG) begin
         c.val = -LIM_POS;
         c.sat = 1'b1;
      end else begin
         c.val = x[SW-1:0];
         c.sat = 1'b0;
      end
      return c;
   endfunction

   function automatic logic [MW-1:0] mag_of(input logic signed [SW-1:0] x);
      logic signed [SW-1:0] n;
      n = -x;
      return x[SW-1] ? MW'(n) : MW'(x);
   endfunction

endpackage

[src/kem_front.sv]
// kem_front: input clamp, kinetic energy, singularity clamp and divisor set-up stages
// depends on kem_pkg
module kem_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  kem_pkg::req_type   in_data,
   output logic               out_valid,
   output kem_pkg::front_type out_data
);

   typedef struct packed {
      logic signed [kem_pkg::SW-1:0] te;
      logic signed [kem_pkg::SW-1:0] pot;
      logic signed [kem_pkg::SW-1:0] eg;
      logic signed [kem_pkg::SW-1:0] so;
      logic signed [kem_pkg::SW-1:0] kf;
      logic signed [kem_pkg::SW-1:0] ep;
      logic                          last;
      logic                          sat;
   } st_type;

   logic [kem_pkg::FRONT_STAGES-1:0] valid_ff, valid_in;
   kem_pkg::req_type   cap_ff;
   st_type             st1_ff, st1_in, st2_ff, st2_in, st3_ff, st3_in, st4_ff, st4_in;
   kem_pkg::front_type out_ff, out_in;

   assign valid_in = {valid_ff[kem_pkg::FRONT_STAGES-2:0], in_valid};

   always_comb begin
      kem_pkg::clamp_type c0, c1, c2, c3, c4, c5;
      c0 = kem_pkg::clamp_lim(kem_pkg::XW'(cap_ff.trial_energy));
      c1 = kem_pkg::clamp_lim(kem_pkg::XW'(cap_ff.band_potential));
      c2 = kem_pkg::clamp_lim(kem_pkg::XW'(cap_ff.gap_energy));
      c3 = kem_pkg::clamp_lim(kem_pkg::XW'(cap_ff.kane_param));
      c4 = kem_pkg::clamp_lim(kem_pkg::XW'(cap_ff.matrix_energy));
      c5 = kem_pkg::clamp_lim(kem_pkg::XW'(cap_ff.split_off_energy));
      st1_in.te   = c0.val;
      st1_in.pot  = c1.val;
      st1_in.eg   = c2.val;
      st1_in.kf   = c3.val;
      st1_in.ep   = c4.val;
      st1_in.so   = c5.val;
      st1_in.last = cap_ff.last_position;
      st1_in.sat  = c0.sat | c1.sat | c2.sat | c3.sat | c4.sat | c5.sat;
   end

   // kinetic energy
   always_comb begin
      kem_pkg::clamp_type c;
      c = kem_pkg::clamp_lim(kem_pkg::XW'(st1_ff.te) - kem_pkg::XW'(st1_ff.pot));
      st2_in     = st1_ff;
      st2_in.te  = c.val;
      st2_in.sat = st1_ff.sat | c.sat;
   end

   // e + gap, clamped to 2 lsb when negative
   always_comb begin
      kem_pkg::clamp_type c;
      c = kem_pkg::clamp_lim(kem_pkg::XW'(st2_ff.te) + kem_pkg::XW'(st2_ff.eg));
      st3_in     = st2_ff;
      st3_in.te  = c.val[kem_pkg::SW-1] ? kem_pkg::SW'(2) : c.val;
      st3_in.sat = st2_ff.sat | c.sat;
   end

   // plus split-off, kept in pot
   always_comb begin
      kem_pkg::clamp_type c;
      c = kem_pkg::clamp_lim(kem_pkg::XW'(st3_ff.te) + kem_pkg::XW'(st3_ff.so));
      st4_in     = st3_ff;
      st4_in.pot = c.val;
      st4_in.sat = st3_ff.sat | c.sat;
   end

   always_comb begin
      kem_pkg::clamp_type kk;
      logic [kem_pkg::MW-1:0] m2;
      logic z1, z2;
      kk = kem_pkg::clamp_lim(kem_pkg::XW'(st4_ff.kf) + kem_pkg::XW'(st4_ff.kf));
      m2 = kem_pkg::mag_of(st4_ff.pot);
      z1 = (st4_ff.te == '0);
      z2 = (m2 == '0);
      out_in.div1        = z1 ? kem_pkg::DVW'(1) : kem_pkg::DVW'(st4_ff.te);
      out_in.div2        = z2 ? kem_pkg::DVW'(1) : {m2, 1'b0};
      out_in.side.zero1  = z1;
      out_in.side.zero2  = z2;
      out_in.side.neg2   = st4_ff.pot[kem_pkg::SW-1];
      out_in.side.kane2  = kk.val;
      out_in.side.matrix = st4_ff.ep;
      out_in.side.last   = st4_ff.last;
      out_in.side.sat    = st4_ff.sat | kk.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= in_data;
      st1_ff <= st1_in;
      st2_ff <= st2_in;
      st3_ff <= st3_in;
      st4_ff <= st4_in;
      out_ff <= out_in;
   end

   assign out_valid = valid_ff[kem_pkg::FRONT_STAGES-1];
   assign out_data  = out_ff;

endmodule

[src/kem_div.sv]
// kem_div: pipelined restoring divider, one quotient bit per stage, 2^DIV_EXP / divisor
// depends on kem_pkg
module kem_div (
   input  logic                     clock,
   input  logic [kem_pkg::DVW-1:0]  divisor,
   output logic [kem_pkg::QW-1:0]   quotient
);

   localparam int STAGES = kem_pkg::QW;

   typedef struct packed {
      logic [kem_pkg::DVW-1:0] rem;
      logic [kem_pkg::QW-1:0]  quo;
   } step_type;

   logic [kem_pkg::DVW-1:0] rem_ff [STAGES];
   logic [kem_pkg::DVW-1:0] rem_in [STAGES];
   logic [kem_pkg::QW-1:0]  quo_ff [STAGES];
   logic [kem_pkg::QW-1:0]  quo_in [STAGES];
   logic [kem_pkg::DVW-1:0] dvs_ff [STAGES];
   logic [kem_pkg::DVW-1:0] dvs_in [STAGES];

   function automatic step_type div_step(input logic [kem_pkg::DVW-1:0] r,
                                         input logic [kem_pkg::QW-1:0]  q,
                                         input logic [kem_pkg::DVW-1:0] d,
                                         input logic                    b);
      step_type res;
      logic [kem_pkg::DVW:0] trial;
      logic [kem_pkg::DVW:0] diff;
      trial = {r, b};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         res.rem = diff[kem_pkg::DVW-1:0];
         res.quo = {q[kem_pkg::QW-2:0], 1'b1};
      end else begin
         res.rem = trial[kem_pkg::DVW-1:0];
         res.quo = {q[kem_pkg::QW-2:0], 1'b0};
      end
      return res;
   endfunction

   always_comb begin
      step_type s;
      s         = div_step('0, '0, divisor, 1'b1);
      rem_in[0] = s.rem;
      quo_in[0] = s.quo;
      dvs_in[0] = divisor;
      for (int i = 1; i < STAGES; i++) begin
         s         = div_step(rem_ff[i-1], quo_ff[i-1], dvs_ff[i-1], 1'b0);
         rem_in[i] = s.rem;
         quo_in[i] = s.quo;
         dvs_in[i] = dvs_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
         dvs_ff[i] <= dvs_in[i];
      end
   end

   assign quotient = quo_ff[STAGES-1];

endmodule

[src/kem_mid.sv]
// kem_mid: reciprocal sum, matrix element product, divide by three and denominator stages
// depends on kem_pkg
module kem_mid (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [kem_pkg::QW-1:0]  quo1,
   input  logic [kem_pkg::QW-1:0]  quo2,
   input  kem_pkg::side_type       side,
   input  logic                    band_model,
   output logic                    out_valid,
   output kem_pkg::mid_type        out_data
);

   localparam int PRW = 2 * kem_pkg::PW;
   localparam int NS  = kem_pkg::D3_STAGES;

   typedef struct packed {
      logic [1:0]                   rem;
      logic [kem_pkg::D3_CHUNK-1:0] quo;
   } d3_type;

   function automatic d3_type div3_chunk(input logic [1:0] r,
                                         input logic [kem_pkg::D3_CHUNK-1:0] bits);
      d3_type res;
      logic [2:0] t;
      res.rem = r;
      res.quo = '0;
      for (int k = kem_pkg::D3_CHUNK - 1; k >= 0; k--) begin
         t = {res.rem, bits[k]};
         if (t >= 3'd3) begin
            res.rem    = 2'(t - 3'd3);
            res.quo[k] = 1'b1;
         end else begin
            res.rem = t[1:0];
         end
      end
      return res;
   endfunction

   logic [kem_pkg::MID_STAGES-1:0] valid_ff, valid_in;

   logic signed [kem_pkg::SW-1:0] sum1_ff, sum1_in, ep1_ff, kk1_ff;
   logic                          last1_ff, sat1_ff, sat1_in;

   logic [kem_pkg::PW-1:0]        pll_ff, plh_ff, phl_ff, phh_ff;
   logic [kem_pkg::PW-1:0]        pll_in, plh_in, phl_in, phh_in;
   logic                          neg2_ff, neg2_in, last2_ff, sat2_ff;
   logic signed [kem_pkg::SW-1:0] kk2_ff;

   logic [kem_pkg::MW-1:0]        mag3_ff, mag3_in;
   logic                          neg3_ff, last3_ff, sat3_ff, sat3_in;
   logic signed [kem_pkg::SW-1:0] kk3_ff;

   logic [kem_pkg::D3W-1:0]       d3x_ff [NS];
   logic [kem_pkg::D3W-1:0]       d3x_in [NS];
   logic [kem_pkg::D3W-1:0]       d3q_ff [NS];
   logic [kem_pkg::D3W-1:0]       d3q_in [NS];
   logic [1:0]                    d3r_ff [NS];
   logic [1:0]                    d3r_in [NS];
   logic                          d3neg_ff [NS];
   logic                          d3neg_in [NS];
   logic                          d3last_ff [NS];
   logic                          d3last_in [NS];
   logic                          d3sat_ff [NS];
   logic                          d3sat_in [NS];
   logic signed [kem_pkg::SW-1:0] d3kk_ff [NS];
   logic signed [kem_pkg::SW-1:0] d3kk_in [NS];

   logic signed [kem_pkg::SW-1:0] dena_ff, dena_in, kk12_ff, den_ff, den_in;
   logic                          last12_ff, sat12_ff, sat12_in, last13_ff, sat13_ff, sat13_in;

   kem_pkg::mid_type out_ff, out_in;

   assign valid_in = {valid_ff[kem_pkg::MID_STAGES-2:0], in_valid};

   // reciprocal terms and their sum
   always_comb begin
      logic signed [kem_pkg::SW-1:0] r1, r2, q1s, q2s;
      kem_pkg::clamp_type c;
      q1s = kem_pkg::SW'(quo1);
      q2s = kem_pkg::SW'(quo2);
      r1  = side.zero1 ? kem_pkg::LIM_POS : q1s;
      r2  = side.zero2 ? kem_pkg::LIM_POS : (side.neg2 ? -q2s : q2s);
      c   = kem_pkg::clamp_lim(kem_pkg::XW'(r1) + kem_pkg::XW'(r2));
      sum1_in = c.val;
      sat1_in = side.sat | side.zero1 | side.zero2 | c.sat;
   end

   // partial products on magnitudes
   always_comb begin
      logic [kem_pkg::PW-1:0] ap, bp;
      ap = kem_pkg::PW'(kem_pkg::mag_of(ep1_ff));
      bp = kem_pkg::PW'(kem_pkg::mag_of(sum1_ff));
      pll_in  = ap[kem_pkg::HW-1:0] * bp[kem_pkg::HW-1:0];
      plh_in  = ap[kem_pkg::HW-1:0] * bp[kem_pkg::PW-1:kem_pkg::HW];
      phl_in  = ap[kem_pkg::PW-1:kem_pkg::HW] * bp[kem_pkg::HW-1:0];
      phh_in  = ap[kem_pkg::PW-1:kem_pkg::HW] * bp[kem_pkg::PW-1:kem_pkg::HW];
      neg2_in = ep1_ff[kem_pkg::SW-1] ^ sum1_ff[kem_pkg::SW-1];
   end

   always_comb begin
      logic [PRW-1:0] prod, shifted;
      prod = (PRW'(phh_ff) << (2 * kem_pkg::HW)) + (PRW'(phl_ff) << kem_pkg::HW)
           + (PRW'(plh_ff) << kem_pkg::HW) + PRW'(pll_ff);
      shifted = prod >> kem_pkg::FRACTION_BITS;
      if (shifted > (PRW'(1) << kem_pkg::LIM_BITS)) begin
         mag3_in = kem_pkg::LIM_MAG;
         sat3_in = 1'b1;
      end else begin
         mag3_in = shifted[kem_pkg::MW-1:0];
         sat3_in = 1'b0;
      end
   end

   // divide by three, one chunk per stage, msb first
   always_comb begin
      d3_type c;
      logic [kem_pkg::D3W-1:0] x0;
      x0 = kem_pkg::D3W'(mag3_ff);
      c  = div3_chunk(2'd0, x0[kem_pkg::D3W-1 -: kem_pkg::D3_CHUNK]);
      d3x_in[0]    = x0;
      d3q_in[0]    = '0;
      d3q_in[0][kem_pkg::D3W-1 -: kem_pkg::D3_CHUNK] = c.quo;
      d3r_in[0]    = c.rem;
      d3neg_in[0]  = neg3_ff;
      d3last_in[0] = last3_ff;
      d3sat_in[0]  = sat3_ff;
      d3kk_in[0]   = kk3_ff;
      for (int j = 1; j < NS; j++) begin
         c = div3_chunk(d3r_ff[j-1],
                        d3x_ff[j-1][kem_pkg::D3W-1-j*kem_pkg::D3_CHUNK -: kem_pkg::D3_CHUNK]);
         d3x_in[j] = d3x_ff[j-1];
         d3q_in[j] = d3q_ff[j-1];
         d3q_in[j][kem_pkg::D3W-1-j*kem_pkg::D3_CHUNK -: kem_pkg::D3_CHUNK] = c.quo;
         d3r_in[j]    = c.rem;
         d3neg_in[j]  = d3neg_ff[j-1];
         d3last_in[j] = d3last_ff[j-1];
         d3sat_in[j]  = d3sat_ff[j-1];
         d3kk_in[j]   = d3kk_ff[j-1];
      end
   end

   always_comb begin
      logic signed [kem_pkg::SW-1:0] qs, t;
      kem_pkg::clamp_type c;
      qs = kem_pkg::SW'(d3q_ff[NS-1]);
      t  = d3neg_ff[NS-1] ? -qs : qs;
      c  = kem_pkg::clamp_lim(kem_pkg::XW'(kem_pkg::ONE_Q) + kem_pkg::XW'(t));
      dena_in  = c.val;
      sat12_in = d3sat_ff[NS-1] | c.sat;
   end

   // kane term in zincblende mode only
   always_comb begin
      kem_pkg::clamp_type c;
      c = kem_pkg::clamp_lim(kem_pkg::XW'(dena_ff) + kem_pkg::XW'(kk12_ff));
      if (band_model == kem_pkg::MODEL_ZINCBLENDE) begin
         den_in   = c.val;
         sat13_in = sat12_ff | c.sat;
      end else begin
         den_in   = dena_ff;
         sat13_in = sat12_ff;
      end
   end

   always_comb begin
      logic z;
      z = (den_ff == '0);
      out_in.div3       = z ? kem_pkg::DVW'(1) : {kem_pkg::mag_of(den_ff), 1'b0};
      out_in.side.zero3 = z;
      out_in.side.neg3  = den_ff[kem_pkg::SW-1];
      out_in.side.last  = last13_ff;
      out_in.side.sat   = sat13_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum1_ff  <= sum1_in;
      ep1_ff   <= side.matrix;
      kk1_ff   <= side.kane2;
      last1_ff <= side.last;
      sat1_ff  <= sat1_in;
      pll_ff   <= pll_in;
      plh_ff   <= plh_in;
      phl_ff   <= phl_in;
      phh_ff   <= phh_in;
      neg2_ff  <= neg2_in;
      kk2_ff   <= kk1_ff;
      last2_ff <= last1_ff;
      sat2_ff  <= sat1_ff;
      mag3_ff  <= mag3_in;
      neg3_ff  <= neg2_ff;
      kk3_ff   <= kk2_ff;
      last3_ff <= last2_ff;
      sat3_ff  <= sat2_ff | sat3_in;
      for (int j = 0; j < NS; j++) begin
         d3x_ff[j]    <= d3x_in[j];
         d3q_ff[j]    <= d3q_in[j];
         d3r_ff[j]    <= d3r_in[j];
         d3neg_ff[j]  <= d3neg_in[j];
         d3last_ff[j] <= d3last_in[j];
         d3sat_ff[j]  <= d3sat_in[j];
         d3kk_ff[j]   <= d3kk_in[j];
      end
      dena_ff   <= dena_in;
      kk12_ff   <= d3kk_ff[NS-1];
      last12_ff <= d3last_ff[NS-1];
      sat12_ff  <= sat12_in;
      den_ff    <= den_in;
      last13_ff <= last12_ff;
      sat13_ff  <= sat13_in;
      out_ff    <= out_in;
   end

   assign out_valid = valid_ff[kem_pkg::MID_STAGES-1];
   assign out_data  = out_ff;

endmodule

[src/kem_back.sv]
// kem_back: sign, output range clamp and zero denominator handling, result register
// depends on kem_pkg
module kem_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [kem_pkg::QW-1:0] quo3,
   input  kem_pkg::side3_type     side,
   output logic                   rsp_valid,
   output kem_pkg::rsp_type       rsp_data
);

   localparam logic signed [kem_pkg::DATA_WIDTH-1:0] MAX_OUT =
      {1'b0, {(kem_pkg::DATA_WIDTH-1){1'b1}}};
   localparam logic signed [kem_pkg::DATA_WIDTH-1:0] MIN_OUT =
      {1'b1, {(kem_pkg::DATA_WIDTH-1){1'b0}}};

   logic             valid_ff;
   kem_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic [kem_pkg::CW-1:0] mag, negv;
      mag  = kem_pkg::CW'(quo3);
      negv = -mag;
      rsp_in.last_out  = side.last;
      rsp_in.saturated = side.sat;
      if (side.zero3) begin
         rsp_in.mass_ratio = MAX_OUT;
         rsp_in.saturated  = 1'b1;
      end else if (side.neg3) begin
         if (mag > kem_pkg::OUT_NEG_MAG) begin
            rsp_in.mass_ratio = MIN_OUT;
            rsp_in.saturated  = 1'b1;
         end else begin
            rsp_in.mass_ratio = negv[kem_pkg::DATA_WIDTH-1:0];
         end
      end else begin
         if (mag > kem_pkg::OUT_POS_MAX) begin
            rsp_in.mass_ratio = MAX_OUT;
            rsp_in.saturated  = 1'b1;
         end else begin
            rsp_in.mass_ratio = mag[kem_pkg::DATA_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/kane_effective_mass_top.sv]
// a position goes through kem_front, u_div1/u_div2, kem_mid, u_div3 and kem_back
// throughput: one position per cycle, busy stays low; the three pipelined dividers
// (one quotient bit per stage, 50 stages each) set most of the depth
// results are strobed for one cycle and cannot be stalled
// synchronous reset empties the pipeline and sets band_model to zincblende
// depends on kem_pkg, kem_front, kem_div, kem_mid, kem_back
module kane_effective_mass_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  kem_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output kem_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [kem_pkg::PADDR_WIDTH-1:0] paddr,
   input  logic [kem_pkg::CSR_WIDTH-1:0]   pwdata,
   output logic [kem_pkg::CSR_WIDTH-1:0]   prdata,
   output logic                            pready
);

   localparam int QW = kem_pkg::QW;

   logic band_model_ff, band_model_in;

   logic               front_valid;
   kem_pkg::front_type front_data;
   logic [QW-1:0]      quo1, quo2, quo3;

   logic [QW-1:0]      dv1_ff, dv1_in;
   kem_pkg::side_type  side_ff [QW];

   logic               mid_valid;
   kem_pkg::mid_type   mid_data;
   logic [QW-1:0]      dv3_ff, dv3_in;
   kem_pkg::side3_type side3_ff [QW];

   assign busy   = 1'b0;
   assign pready = 1'b1;

   always_comb begin
      band_model_in = band_model_ff;
      if (psel && penable && pwrite && (paddr[kem_pkg::PADDR_WIDTH-1] == kem_pkg::REG_BAND_MODEL))
      begin
         band_model_in = pwdata[0];
      end
   end

   assign prdata = (paddr[kem_pkg::PADDR_WIDTH-1] == kem_pkg::REG_BAND_MODEL) ?
                   kem_pkg::CSR_WIDTH'(band_model_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_model_ff <= kem_pkg::MODEL_ZINCBLENDE;
         dv1_ff        <= '0;
         dv3_ff        <= '0;
      end else begin
         band_model_ff <= band_model_in;
         dv1_ff        <= dv1_in;
         dv3_ff        <= dv3_in;
      end
   end

   assign dv1_in = {dv1_ff[QW-2:0], front_valid};
   assign dv3_in = {dv3_ff[QW-2:0], mid_valid};

   // sideband travels beside the dividers
   always_ff @(posedge clock) begin
      side_ff[0]  <= front_data.side;
      side3_ff[0] <= mid_data.side;
      for (int i = 1; i < QW; i++) begin
         side_ff[i]  <= side_ff[i-1];
         side3_ff[i] <= side3_ff[i-1];
      end
   end

   kem_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   kem_div u_div1 (
      .clock    (clock),
      .divisor  (front_data.div1),
      .quotient (quo1)
   );

   kem_div u_div2 (
      .clock    (clock),
      .divisor  (front_data.div2),
      .quotient (quo2)
   );

   kem_mid u_mid (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv1_ff[QW-1]),
      .quo1       (quo1),
      .quo2       (quo2),
      .side       (side_ff[QW-1]),
      .band_model (band_model_ff),
      .out_valid  (mid_valid),
      .out_data   (mid_data)
   );

   kem_div u_div3 (
      .clock    (clock),
      .divisor  (mid_data.div3),
      .quotient (quo3)
   );

   kem_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv3_ff[QW-1]),
      .quo3      (quo3),
      .side      (side3_ff[QW-1]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[src/kem_checker.sv]
// kem_checker: port-level timing checks of the effective mass pipeline, bound to the top
// depends on kem_pkg, kane_effective_mass_top
module kem_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input kem_pkg::req_type req_data,
   input logic             rsp_valid,
   input kem_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   a_transfer_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(kem_pkg::PIPE_LATENCY) rsp_valid)
      else $error("accepted transfer gave no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, kem_pkg::PIPE_LATENCY))
      else $error("result without an accepted transfer");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(kem_pkg::PIPE_LATENCY)
      (rsp_data.last_out == $past(req_data.last_position, kem_pkg::PIPE_LATENCY)))
      else $error("last flag lost in the pipeline");

endmodule

bind kane_effective_mass_top kem_checker u_kem_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

[test/tb_top.sv]
// tb_top: self-checking testbench for kane_effective_mass_top, with an in-bench fixed-point
// predictor of the effective mass and a scoreboard of expected results
// depends on kem_pkg and the kane_effective_mass_top rtl
`timescale 1ns / 1ps

class mass_scoreboard;
   localparam int FB = kem_pkg::FRACTION_BITS;
   localparam int DW = kem_pkg::DATA_WIDTH;
   localparam longint LIM = longint'(1) << 61;

   kem_pkg::rsp_type expected_q[$];
   bit band_model;
   bit sat;
   int fails;

   function longint clampv(longint x);
      if (x > LIM) begin
         sat = 1;
         return LIM;
      end
      if (x < -LIM) begin
         sat = 1;
         return -LIM;
      end
      return x;
   endfunction

   function longint signv(logic [63:0] mag, bit neg);
      if (mag > 64'(LIM)) begin
         sat = 1;
         mag = 64'(LIM);
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function logic [63:0] magv(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function longint mul_q(longint a, longint b);
      logic [127:0] p;
      bit neg;
      p = {64'b0, magv(a)} * {64'b0, magv(b)};
      neg = (a < 0) != (b < 0);
      if ((p >> (FB + 64)) != 0) return signv(64'(LIM) + 1, neg);
      return signv(64'(p >> FB), neg);
   endfunction

   function longint div_q(longint n, longint d);
      logic [63:0] un, ud, q, r;
      bit neg;
      bit b;
      un = magv(n);
      ud = magv(d);
      q = 0;
      r = 0;
      neg = (n < 0) != (d < 0);
      for (int i = 61 + FB; i >= 0; i--) begin
         b = (i >= FB) ? un[i - FB] : 1'b0;
         r = {r[62:0], b};
         q = q << 1;
         if (r >= ud) begin
            r = r - ud;
            q[0] = 1'b1;
         end
         if (q > 64'(LIM)) return signv(q, neg);
      end
      return signv(q, neg);
   endfunction

   function longint recip(longint num, longint den);
      if (den == 0) begin
         sat = 1;
         return LIM;
      end
      return div_q(num, den);
   endfunction

   function kem_pkg::rsp_type mass_of(kem_pkg::req_type d);
      kem_pkg::rsp_type r;
      longint one, maxv, minv, e, s1, s2, total, den, m;
      one = longint'(1) << FB;
      maxv = (longint'(1) << (DW - 1)) - 1;
      minv = -maxv - 1;
      sat = 0;
      e = clampv(longint'(d.trial_energy) - longint'(d.band_potential));
      s1 = clampv(e + longint'(d.gap_energy));
      if (s1 < 0) s1 = 2;
      s2 = clampv(s1 + longint'(d.split_off_energy));
      total = clampv(recip(2 * one, s1) + recip(one, s2));
      den = clampv(one + mul_q(longint'(d.matrix_energy), total) / 3);
      if (band_model == kem_pkg::MODEL_ZINCBLENDE)
         den = clampv(den + clampv(longint'(d.kane_param) + longint'(d.kane_param)));
      if (den == 0) begin
         sat = 1;
         m = maxv;
      end else begin
         m = div_q(one, den);
         if (m > maxv) begin
            sat = 1;
            m = maxv;
         end
         if (m < minv) begin
            sat = 1;
            m = minv;
         end
      end
      r.mass_ratio = DW'(m);
      r.saturated = sat;
      r.last_out = d.last_position;
      return r;
   endfunction

   function void note_position(kem_pkg::req_type d);
      expected_q.push_back(mass_of(d));
   endfunction

   function void check_mass(kem_pkg::rsp_type got);
      kem_pkg::rsp_type exp_r;
      if (expected_q.size() == 0) begin
         $error("unexpected result transfer mass_ratio=%h", got.mass_ratio);
         fails++;
         return;
      end
      exp_r = expected_q.pop_front();
      if (got.mass_ratio !== exp_r.mass_ratio) begin
         $error("mass_ratio expected %h actual %h", exp_r.mass_ratio, got.mass_ratio);
         fails++;
      end
      if (got.saturated !== exp_r.saturated) begin
         $error("saturated expected %b actual %b", exp_r.saturated, got.saturated);
         fails++;
      end
      if (got.last_out !== exp_r.last_out) begin
         $error("last_out expected %b actual %b", exp_r.last_out, got.last_out);
         fails++;
      end
   endfunction
endclass

module tb_top;

   localparam int ONE = 1 << kem_pkg::FRACTION_BITS;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   kem_pkg::req_type req_data;
   logic rsp_valid;
   kem_pkg::rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [kem_pkg::PADDR_WIDTH-1:0] paddr;
   logic [kem_pkg::CSR_WIDTH-1:0] pwdata;
   logic [kem_pkg::CSR_WIDTH-1:0] prdata;
   logic pready;

   mass_scoreboard sb;
   int idle_pct;

   kane_effective_mass_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_position(req_data);
         if (rsp_valid) sb.check_mass(rsp_data);
      end
   end

   task automatic write_band_model(bit v);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= kem_pkg::PADDR_WIDTH'(int'(kem_pkg::REG_BAND_MODEL) * 4);
      pwdata <= kem_pkg::CSR_WIDTH'(v);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.band_model = v;
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic send_position(kem_pkg::req_type d);
      if ($urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data <= d;
      start <= 1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (kem_pkg::PIPE_LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic signed [31:0] ev(int lo_mev, int hi_mev);
      longint v;
      v = longint'($signed($urandom_range(0, hi_mev - lo_mev))) + lo_mev;
      return 32'((v * ONE) / 1000);
   endfunction

   function automatic kem_pkg::req_type mk(int te, int pot, int eg, int kf, int ep, int so);
      kem_pkg::req_type d;
      d.trial_energy = te;
      d.band_potential = pot;
      d.gap_energy = eg;
      d.kane_param = kf;
      d.matrix_energy = ep;
      d.split_off_energy = so;
      d.last_position = 1'($urandom_range(1));
      return d;
   endfunction

   function automatic kem_pkg::req_type random_position();
      kem_pkg::req_type d;
      int k;
      k = $urandom_range(99);
      if (k < 70) begin
         d = mk(ev(-500, 2000), ev(-300, 800), ev(100, 3000), ev(-2000, 500),
                ev(0, 30000), ev(0, 1000));
         if (k < 8) d.trial_energy = d.band_potential - d.gap_energy;
         else if (k < 14) d.trial_energy = d.band_potential - d.gap_energy - ev(1, 500);
         else if (k < 18) d.split_off_energy = -(d.trial_energy - d.band_potential
                                                 + d.gap_energy);
      end else begin
         d = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      return d;
   endfunction

   task automatic directed_positions();
      int mx;
      int mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      send_position(mk(ONE / 10, 0, ONE / 100 * 142, -ONE / 2, 25 * ONE, ONE * 34 / 100));
      send_position(mk(-3 * ONE, 0, ONE, 0, 20 * ONE, ONE / 4));
      send_position(mk(-ONE, 0, ONE, ONE / 3, 20 * ONE, ONE / 4));
      send_position(mk(0, 0, ONE, 0, 20 * ONE, -ONE));
      send_position(mk(ONE, 0, ONE, -ONE / 2, 0, ONE));
      send_position(mk(ONE, 0, ONE, -ONE / 2 + 1, 0, ONE));
      send_position(mk(ONE, 0, ONE, -ONE / 2 - 1, 0, ONE));
      send_position(mk(mx, mx, mx, mx, mx, mx));
      send_position(mk(mn, mn, mn, mn, mn, mn));
      send_position(mk(mx, mn, mx, mn, mx, mx));
      send_position(mk(mn, mx, mn, mx, mn, mn));
      send_position(mk(0, 0, 0, 0, 0, 0));
      send_position(mk(0, 0, 1, 0, mx, 0));
      send_position(mk(ONE, 0, ONE, 0, mn, ONE));
   endtask

   initial begin
      bit modes[4];
      int idles[4];
      modes = '{1'b0, 1'b1, 1'b1, 1'b0};
      idles = '{0, 68, 0, 11};
      sb = new();
      reset = 1;
      start = 0;
      req_data = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int ph = 0; ph < 4; ph++) begin
         write_band_model(modes[ph]);
         idle_pct = idles[ph];
         directed_positions();
         for (int n = 0; n < 280; n++) begin
            if (ph == 2 && n == 100) drain();
            send_position(random_position());
         end
         drain();
      end
      if (sb.fails == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
